/* design/gf256_arithmetic_unit_assert.svh */
// Assertion macros for the GF(256) arithmetic unit.
// Used by modules that include this header; expects clk and rst in scope.
`ifndef GF256_ARITHMETIC_UNIT_ASSERT_SVH
`define GF256_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GFAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GFAU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gfau_pkg.sv */
// Shared types, constants and constant log/exp tables for the GF(256) unit.
// No dependencies.
`default_nettype none

package gfau_pkg;

  localparam logic [8:0] GF_POLY  = 9'h11D;
  localparam logic [8:0] GF_ORDER = 9'd255;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_POW = 2'd2,
    OP_INV = 2'd3
  } op_t;

  // Result class decided up front; SPEC_NONE means the exp table answers.
  typedef enum logic [1:0] {
    SPEC_NONE = 2'd0,
    SPEC_ZERO = 2'd1,
    SPEC_ONE  = 2'd2,
    SPEC_BAD  = 2'd3
  } spec_t;

  typedef struct packed {
    op_t        op;
    spec_t      spec;
    logic [7:0] log_a;
    logic [7:0] log_b;
    logic [7:0] expo;
  } entry_t;

  typedef logic [7:0] gf_tbl_t [256];

  function automatic gf_tbl_t gen_exp();
    gf_tbl_t    t;
    logic [8:0] x;
    x = 9'd1;
    for (int i = 0; i < 256; i++) begin
      t[i] = x[7:0];
      x = x << 1;
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return t;
  endfunction

  function automatic gf_tbl_t gen_log();
    gf_tbl_t    t;
    logic [8:0] x;
    x = 9'd1;
    t[0] = 8'd0;
    for (int i = 0; i < 255; i++) begin
      t[x[7:0]] = 8'(i);
      x = x << 1;
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return t;
  endfunction

  localparam gf_tbl_t EXP_TBL = gen_exp();
  localparam gf_tbl_t LOG_TBL = gen_log();

endpackage

`default_nettype wire

/* design/gfau_req_if.sv */
// Request channel: operation kind and two byte operands.
// No dependencies.
`default_nettype none

interface gfau_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] operand_a;
  logic [7:0] operand_b;

  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

/* design/gfau_rsp_if.sv */
// Response channel: result byte and invalid flag.
// No dependencies.
`default_nettype none

interface gfau_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic       invalid;

  modport source (output valid, result, invalid, input ready);
  modport sink   (input valid, result, invalid, output ready);
endinterface

`default_nettype wire

/* design/gf256_arithmetic_unit.sv */
// GF(256) arithmetic unit, polynomial 0x11D: multiply, divide, power, inverse.
// A request goes through a queue entry and then the result register before the response.
// Throughput: 1 item per cycle unless rsp stalls; the QUEUE_DEPTH-entry queue absorbs them.
// Reset: synchronous rst empties the queue and drops the result register; no tables to clear.
// Depends on gfau_pkg, gfau_req_if, gfau_rsp_if, gfau_front, gfau_queue, gfau_back.
`default_nettype none

module gf256_arithmetic_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  gfau_req_if.sink   req,
  gfau_rsp_if.source rsp
);
  import gfau_pkg::*;

  // front -> queue
  logic   push;
  entry_t push_data;
  logic   q_full;

  // queue -> back
  logic   q_valid;
  entry_t q_data;
  logic   pop;

  // Front: log lookups and special-case classification, combinational on the request.
  gfau_front u_front (
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Decouples request acceptance from response backpressure.
  gfau_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // Back: index arithmetic modulo 255, result register, exp table on the output.
  gfau_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

/* design/gfau_front.sv */
// Front end: takes request items, looks up operand logs, classifies special cases.
// Depends on gfau_pkg and gfau_req_if.
`default_nettype none

module gfau_front (
  gfau_req_if.sink         req,
  input  logic             q_full,
  output logic             push,
  output gfau_pkg::entry_t push_data
);
  import gfau_pkg::*;

  logic a_zero;
  logic b_zero;
  op_t  op;

  assign a_zero    = (req.operand_a == 8'd0);
  assign b_zero    = (req.operand_b == 8'd0);
  assign op        = op_t'(req.kind);
  assign req.ready = !q_full;
  assign push      = req.valid;

  always_comb begin
    push_data.op    = op;
    push_data.log_a = LOG_TBL[req.operand_a];
    push_data.log_b = LOG_TBL[req.operand_b];
    push_data.expo  = req.operand_b;
    push_data.spec  = SPEC_NONE;
    unique case (op)
      OP_MUL: begin
        if (a_zero || b_zero) push_data.spec = SPEC_ZERO;
      end
      OP_DIV: begin
        priority if (b_zero) push_data.spec = SPEC_BAD;
        else if (a_zero)     push_data.spec = SPEC_ZERO;
        else                 push_data.spec = SPEC_NONE;
      end
      OP_POW: begin
        // zero exponent wins over zero base
        priority if (b_zero) push_data.spec = SPEC_ONE;
        else if (a_zero)     push_data.spec = SPEC_ZERO;
        else                 push_data.spec = SPEC_NONE;
      end
      OP_INV: begin
        if (a_zero) push_data.spec = SPEC_BAD;
      end
      default: push_data.spec = SPEC_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* design/gfau_queue.sv */
// Short queue between front and back end.
// Depends on gfau_pkg and gf256_arithmetic_unit_assert.svh.
`default_nettype none

module gfau_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gfau_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output gfau_pkg::entry_t q_data
);
  import gfau_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == DEPTH_C);
  assign q_valid = (count != '0);
  assign q_data  = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      if (do_pop)  rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`include "gf256_arithmetic_unit_assert.svh"

  `GFAU_ASSERT_IMP(a_count_bound, 1'b1, count <= DEPTH_C, "queue count over depth")
  `GFAU_ASSERT_IMP(a_empty_ptrs, count == '0, rptr == wptr, "empty queue with split pointers")
  `GFAU_ASSERT_NXT(a_push_only, do_push && !do_pop, count == $past(count) + 1'b1,
                   "push did not grow queue")

endmodule

`default_nettype wire

/* design/gfau_back.sv */
// Back end: forms the exp table index from the logs and holds the result register.
// Depends on gfau_pkg and gfau_rsp_if.
`default_nettype none

module gfau_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  gfau_pkg::entry_t q_data,
  output logic             pop,
  gfau_rsp_if.source       rsp
);
  import gfau_pkg::*;

  logic        ovalid;
  logic [7:0]  oidx;
  spec_t       ospec;
  logic [7:0]  idx;
  logic [8:0]  sum;
  logic [8:0]  diff;
  logic [15:0] prod;
  logic [8:0]  fold1;
  logic [8:0]  fold2;

  assign pop = q_valid && (!ovalid || rsp.ready);

  // 256 = 1 mod 255, so folding bytes reduces modulo the group order
  always_comb begin
    sum   = {1'b0, q_data.log_a} + {1'b0, q_data.log_b};
    diff  = {1'b0, q_data.log_a} - {1'b0, q_data.log_b};
    prod  = {8'd0, q_data.log_a} * {8'd0, q_data.expo};
    fold1 = {1'b0, prod[15:8]} + {1'b0, prod[7:0]};
    fold2 = {8'd0, fold1[8]} + {1'b0, fold1[7:0]};
    unique case (q_data.op)
      OP_MUL: idx = (sum >= GF_ORDER) ? 8'(sum - GF_ORDER) : sum[7:0];
      OP_DIV: idx = diff[8] ? 8'(diff + GF_ORDER) : diff[7:0];
      OP_POW: idx = (fold2 == GF_ORDER) ? 8'd0 : fold2[7:0];
      OP_INV: idx = (q_data.log_a == 8'd0) ? 8'd0 : 8'(GF_ORDER - {1'b0, q_data.log_a});
      default: idx = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (pop) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      oidx  <= idx;
      ospec <= q_data.spec;
    end
  end

  assign rsp.valid   = ovalid;
  assign rsp.invalid = (ospec == SPEC_BAD);

  always_comb begin
    unique case (ospec)
      SPEC_NONE: rsp.result = EXP_TBL[oidx];
      SPEC_ONE:  rsp.result = 8'd1;
      SPEC_ZERO: rsp.result = 8'd0;
      SPEC_BAD:  rsp.result = 8'd0;
      default:   rsp.result = 8'd0;
    endcase
  end

endmodule

`default_nettype wire
